>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Hold expr at every clock edge outside reset.
`define PBJ_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Require cons in the cycle after ante.
`define PBJ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PBJ_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)

`define PBJ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/core/pbj_pkg.sv
// ----------------------------------------------------------------------------
// pbj_pkg
// Shared constants, codes and types of the playback jitter buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package pbj_pkg;

    localparam int PBJ_DEPTH_DEF = 8192;
    localparam int PBJ_CHUNK_DEF = 64;

    localparam int FUNC_W   = 3;
    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int GAIN_W   = 10;
    localparam int MARK_W   = 14;
    localparam int MS_W     = 16;
    localparam int CNT_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;

    localparam int PBJ_SMP_MAX = 32767;
    localparam int PBJ_SMP_MIN = -32768;

    // Request codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DRAIN  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_START  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_END    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DISC   = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 3'd5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREBUF  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REBUF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRACE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL    = 3'd4;

    // Register reset values
    localparam logic [GAIN_W-1:0] GAIN_RST   = 10'd256;
    localparam logic [MARK_W-1:0] PREBUF_RST = 14'd2048;
    localparam logic [MARK_W-1:0] REBUF_RST  = 14'd4096;
    localparam logic [MS_W-1:0]   GRACE_RST  = 16'd300;
    localparam logic [MS_W-1:0]   TAIL_RST   = 16'd100;

    typedef struct packed {
        logic mul_en;
        logic sat_en;
    } pbj_scl_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/pbj_if.sv
// ----------------------------------------------------------------------------
// pbj_if
// Valid/ready channels of the jitter buffer: requests, results, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbj_req_if import pbj_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic        [FUNC_W-1:0]   func;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       packet_last;
    logic        [TIME_W-1:0]   now_ms;

    modport source (output valid, func, sample_in, packet_last, now_ms, input ready);
    modport sink   (input valid, func, sample_in, packet_last, now_ms, output ready);
endinterface

interface pbj_res_if import pbj_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       chunk_last;
    logic                       is_reply;
    logic                       finished;
    logic        [CNT_W-1:0]    underrun_total;
    logic        [CNT_W-1:0]    overflow_total;

    modport source (output valid, out_sample, chunk_last, is_reply, finished,
                    underrun_total, overflow_total, input ready);
    modport sink   (input valid, out_sample, chunk_last, is_reply, finished,
                    underrun_total, overflow_total, output ready);
endinterface

interface pbj_cfg_if import pbj_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/playback_jitter_buffer_core.sv
// ----------------------------------------------------------------------------
// playback_jitter_buffer_core
// Jitter buffer for 16-bit playback samples with prebuffer and rebuffer marks.
// ----------------------------------------------------------------------------
// Usage:
//   request : push, drain, session start, stream end, discard, finished query.
//             One request is taken at a time; ready is high only while idle.
//   result  : scaled samples of a drained chunk (chunk_last on the last one)
//             and one reply per finished query.
//   cfg     : register writes, always ready; write only while the block idles.
// Sequence (from acceptance):
//   push, start, end, discard: executed in S_EXEC, no result.
//   drain: a decision in S_EXEC, then for each emitted sample in turn
//   the memory read, the gain multiply, the saturation stage and the send.
//   Finished query: one reply, sent from S_EXEC once the result register is free.
//   The sequencer and the single shared gain unit set this order.
// Stall: the result register holds its item until taken; the sequencer
//   waits on it, and a new request is taken while the last result waits.
// Reset: clears session state, counters and registers to their reset values;
//   sample memory content is undefined and never read before it is written.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module playback_jitter_buffer_core import pbj_pkg::*; #(
    parameter int DEPTH = PBJ_DEPTH_DEF,
    parameter int CHUNK = PBJ_CHUNK_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pbj_req_if.sink   request,
    pbj_res_if.source result,
    pbj_cfg_if.sink   cfg
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int MW = (FW > MARK_W) ? FW : MARK_W;
    localparam int KW = $clog2(CHUNK + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SAT  = 3'd4;
    localparam logic [2:0] S_SEND = 3'd5;

    logic [2:0] state_reg, state_next;

    // Latched request
    logic [FUNC_W-1:0]   func_reg;
    logic [SAMPLE_W-1:0] smp_reg;
    logic                pkt_last_reg;
    logic [TIME_W-1:0]   now_reg;

    // Registers
    logic [GAIN_W-1:0] gain_reg;
    logic [MARK_W-1:0] prebuf_reg;
    logic [MARK_W-1:0] rebuf_reg;
    logic [MS_W-1:0]   grace_reg;
    logic [MS_W-1:0]   tail_reg;

    // Ring and session state
    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     wr_reg, wr_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic              active_reg, active_next;
    logic              end_seen_reg, end_seen_next;
    logic              playing_reg, playing_next;
    logic              rebuf_flag_reg, rebuf_flag_next;
    logic              dropped_reg, dropped_next;
    logic              empty_valid_reg, empty_valid_next;
    logic [TIME_W-1:0] empty_since_reg, empty_since_next;
    logic [TIME_W-1:0] last_out_reg, last_out_next;
    logic [CNT_W-1:0]  under_cnt_reg, under_cnt_next;
    logic [CNT_W-1:0]  over_cnt_reg, over_cnt_next;
    logic [KW-1:0]     chunk_len_reg, chunk_len_next;
    logic [KW-1:0]     idx_reg, idx_next;

    // Result register
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_smp_reg, out_smp_next;
    logic                out_last_reg, out_last_next;
    logic                out_reply_reg, out_reply_next;
    logic                out_fin_reg, out_fin_next;
    logic [CNT_W-1:0]    out_under_reg, out_under_next;
    logic [CNT_W-1:0]    out_over_reg, out_over_next;

    // Datapath links
    logic                mem_wr_en;
    logic                mem_rd_en;
    logic [SAMPLE_W-1:0] mem_rd_data;
    pbj_scl_ctrl_t       scl_ctrl;
    logic [SAMPLE_W-1:0] scaled;

    logic              req_acc;
    logic              out_free;
    logic [AW-1:0]     head_inc;
    logic [AW-1:0]     wr_inc;
    logic              full;
    logic              dropped_now;
    logic [TIME_W-1:0] time_ref;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] time_lim;
    logic              time_ge;
    logic [MW-1:0]     fill_ext;
    logic [MW-1:0]     start_ext;
    logic              chunk_end;
    logic              fin;

    assign req_acc       = request.valid && request.ready;
    assign request.ready = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign out_free      = !out_valid_reg || result.ready;

    assign result.valid          = out_valid_reg;
    assign result.out_sample     = out_smp_reg;
    assign result.chunk_last     = out_last_reg;
    assign result.is_reply       = out_reply_reg;
    assign result.finished       = out_fin_reg;
    assign result.underrun_total = out_under_reg;
    assign result.overflow_total = out_over_reg;

    // Wrap the ring pointers at DEPTH.
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign wr_inc   = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
    assign full     = (fill_reg == FW'(DEPTH));
    assign dropped_now = dropped_reg || full;

    // One shared subtract and compare serves the grace and the tail checks.
    assign time_ref = (func_reg == FUNC_DRAIN) ? empty_since_reg : last_out_reg;
    assign time_lim = {{(TIME_W-MS_W){1'b0}},
                       (func_reg == FUNC_DRAIN) ? grace_reg : tail_reg};
    assign elapsed  = now_reg - time_ref;
    assign time_ge  = (elapsed >= time_lim);

    assign fill_ext  = MW'(fill_reg);
    assign start_ext = MW'(rebuf_flag_reg ? rebuf_reg : prebuf_reg);
    assign chunk_end = ((idx_reg + 1'b1) == chunk_len_reg);
    assign fin = end_seen_reg && (fill_reg == '0) && !(playing_reg && !time_ge);

    pbj_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_reg),
        .wr_data (smp_reg),
        .rd_en   (mem_rd_en),
        .rd_addr (head_reg),
        .rd_data (mem_rd_data)
    );

    pbj_scale u_scale (
        .clk    (clk),
        .ctrl   (scl_ctrl),
        .sample (mem_rd_data),
        .gain   (gain_reg),
        .scaled (scaled)
    );

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        wr_next          = wr_reg;
        fill_next        = fill_reg;
        active_next      = active_reg;
        end_seen_next    = end_seen_reg;
        playing_next     = playing_reg;
        rebuf_flag_next  = rebuf_flag_reg;
        dropped_next     = dropped_reg;
        empty_valid_next = empty_valid_reg;
        empty_since_next = empty_since_reg;
        last_out_next    = last_out_reg;
        under_cnt_next   = under_cnt_reg;
        over_cnt_next    = over_cnt_reg;
        chunk_len_next   = chunk_len_reg;
        idx_next         = idx_reg;

        // Drop the result once taken.
        out_valid_next = out_valid_reg && !result.ready;
        out_smp_next   = out_smp_reg;
        out_last_next  = out_last_reg;
        out_reply_next = out_reply_reg;
        out_fin_next   = out_fin_reg;
        out_under_next = out_under_reg;
        out_over_next  = out_over_reg;

        mem_wr_en       = 1'b0;
        mem_rd_en       = 1'b0;
        scl_ctrl.mul_en = 1'b0;
        scl_ctrl.sat_en = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_IDLE;
                case (func_reg)
                    FUNC_PUSH:
                    begin
                        if (active_reg)
                        begin
                            // Full: drop the oldest sample, fill stays at DEPTH.
                            if (full)
                            begin
                                head_next = head_inc;
                            end
                            else
                            begin
                                fill_next = fill_reg + 1'b1;
                            end
                            mem_wr_en = 1'b1;
                            wr_next   = wr_inc;
                            if (pkt_last_reg)
                            begin
                                if (dropped_now && (over_cnt_reg != '1))
                                begin
                                    over_cnt_next = over_cnt_reg + 1'b1;
                                end
                                dropped_next = 1'b0;
                            end
                            else
                            begin
                                dropped_next = dropped_now;
                            end
                        end
                    end

                    FUNC_DRAIN:
                    begin
                        if (!active_reg)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (playing_reg && (fill_reg == '0) && !end_seen_reg)
                        begin
                            // Starved while playing: time the grace window.
                            if (!empty_valid_reg)
                            begin
                                empty_valid_next = 1'b1;
                                empty_since_next = now_reg;
                            end
                            else if (time_ge)
                            begin
                                playing_next     = 1'b0;
                                rebuf_flag_next  = 1'b1;
                                empty_valid_next = 1'b0;
                                empty_since_next = '0;
                                if (under_cnt_reg != '1)
                                begin
                                    under_cnt_next = under_cnt_reg + 1'b1;
                                end
                            end
                        end
                        else if (fill_reg != '0)
                        begin
                            empty_valid_next = 1'b0;
                            empty_since_next = '0;
                            if (playing_reg || end_seen_reg || (fill_ext >= start_ext))
                            begin
                                playing_next    = 1'b1;
                                rebuf_flag_next = 1'b0;
                                last_out_next   = now_reg;
                                idx_next        = '0;
                                if (fill_ext < MW'(CHUNK))
                                begin
                                    chunk_len_next = KW'(fill_reg);
                                end
                                else
                                begin
                                    chunk_len_next = KW'(CHUNK);
                                end
                                state_next = S_READ;
                            end
                        end
                    end

                    FUNC_START:
                    begin
                        end_seen_next    = 1'b0;
                        playing_next     = 1'b0;
                        rebuf_flag_next  = 1'b0;
                        active_next      = 1'b1;
                        empty_valid_next = 1'b0;
                        empty_since_next = '0;
                        under_cnt_next   = '0;
                        over_cnt_next    = '0;
                        dropped_next     = 1'b0;
                    end

                    FUNC_END:
                    begin
                        end_seen_next = 1'b1;
                    end

                    FUNC_DISC:
                    begin
                        active_next      = 1'b0;
                        head_next        = '0;
                        wr_next          = '0;
                        fill_next        = '0;
                        end_seen_next    = 1'b0;
                        playing_next     = 1'b0;
                        rebuf_flag_next  = 1'b0;
                        empty_valid_next = 1'b0;
                        empty_since_next = '0;
                        dropped_next     = 1'b0;
                    end

                    FUNC_QUERY:
                    begin
                        if (out_free)
                        begin
                            if (fin)
                            begin
                                end_seen_next    = 1'b0;
                                playing_next     = 1'b0;
                                rebuf_flag_next  = 1'b0;
                                active_next      = 1'b0;
                                empty_valid_next = 1'b0;
                                empty_since_next = '0;
                            end
                            out_valid_next = 1'b1;
                            out_smp_next   = '0;
                            out_last_next  = 1'b0;
                            out_reply_next = 1'b1;
                            out_fin_next   = fin;
                            out_under_next = under_cnt_reg;
                            out_over_next  = over_cnt_reg;
                        end
                        else
                        begin
                            // Hold until the result register frees up.
                            state_next = S_EXEC;
                        end
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_READ:
            begin
                mem_rd_en  = 1'b1;
                head_next  = head_inc;
                fill_next  = fill_reg - 1'b1;
                state_next = S_MUL;
            end

            S_MUL:
            begin
                scl_ctrl.mul_en = 1'b1;
                state_next      = S_SAT;
            end

            S_SAT:
            begin
                scl_ctrl.sat_en = 1'b1;
                state_next      = S_SEND;
            end

            S_SEND:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_smp_next   = scaled;
                    out_last_next  = chunk_end;
                    out_reply_next = 1'b0;
                    out_fin_next   = 1'b0;
                    out_under_next = under_cnt_reg;
                    out_over_next  = over_cnt_reg;
                    idx_next       = idx_reg + 1'b1;
                    state_next     = chunk_end ? S_IDLE : S_READ;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            wr_reg          <= '0;
            fill_reg        <= '0;
            active_reg      <= 1'b0;
            end_seen_reg    <= 1'b0;
            playing_reg     <= 1'b0;
            rebuf_flag_reg  <= 1'b0;
            dropped_reg     <= 1'b0;
            empty_valid_reg <= 1'b0;
            empty_since_reg <= '0;
            last_out_reg    <= '0;
            under_cnt_reg   <= '0;
            over_cnt_reg    <= '0;
            chunk_len_reg   <= '0;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            wr_reg          <= wr_next;
            fill_reg        <= fill_next;
            active_reg      <= active_next;
            end_seen_reg    <= end_seen_next;
            playing_reg     <= playing_next;
            rebuf_flag_reg  <= rebuf_flag_next;
            dropped_reg     <= dropped_next;
            empty_valid_reg <= empty_valid_next;
            empty_since_reg <= empty_since_next;
            last_out_reg    <= last_out_next;
            under_cnt_reg   <= under_cnt_next;
            over_cnt_reg    <= over_cnt_next;
            chunk_len_reg   <= chunk_len_next;
            idx_reg         <= idx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result payload and latched request need no reset.
    always_ff @(posedge clk)
    begin
        out_smp_reg   <= out_smp_next;
        out_last_reg  <= out_last_next;
        out_reply_reg <= out_reply_next;
        out_fin_reg   <= out_fin_next;
        out_under_reg <= out_under_next;
        out_over_reg  <= out_over_next;
        if (req_acc)
        begin
            func_reg     <= request.func;
            smp_reg      <= request.sample_in;
            pkt_last_reg <= request.packet_last;
            now_reg      <= request.now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= GAIN_RST;
            prebuf_reg <= PREBUF_RST;
            rebuf_reg  <= REBUF_RST;
            grace_reg  <= GRACE_RST;
            tail_reg   <= TAIL_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_GAIN:   gain_reg   <= cfg.data[GAIN_W-1:0];
                REG_PREBUF: prebuf_reg <= cfg.data[MARK_W-1:0];
                REG_REBUF:  rebuf_reg  <= cfg.data[MARK_W-1:0];
                REG_GRACE:  grace_reg  <= cfg.data[MS_W-1:0];
                REG_TAIL:   tail_reg   <= cfg.data[MS_W-1:0];
                default:    ;
            endcase
        end
    end

    // Expected write pointer, head plus fill modulo DEPTH.
    logic [AW:0] ptr_sum;
    logic [AW:0] ptr_exp;

    assign ptr_sum = {1'b0, head_reg} + (AW+1)'(fill_reg);
    assign ptr_exp = (ptr_sum >= (AW+1)'(DEPTH)) ? ptr_sum - (AW+1)'(DEPTH) : ptr_sum;

    `PBJ_ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_reg <= FW'(DEPTH), "fill above depth")
    `PBJ_ASSERT_ALWAYS(a_wr_ptr, clk, rst_n, wr_reg == ptr_exp[AW-1:0], "write pointer off ring")
    `PBJ_ASSERT_ALWAYS(a_play_rebuf, clk, rst_n, !(playing_reg && rebuf_flag_reg), "playing while rebuffering")
    `PBJ_ASSERT_ALWAYS(a_empty_play, clk, rst_n, !empty_valid_reg || playing_reg, "grace timer without playback")
    `PBJ_ASSERT_NEXT(a_send_last, clk, rst_n, (state_reg == S_SEND) && out_free && chunk_end, (state_reg == S_IDLE) && out_valid_reg && out_last_reg, "chunk end not delivered")

endmodule

`default_nettype wire

>>> rtl/core/pbj_store.sv
// ----------------------------------------------------------------------------
// pbj_store
// Sample ring memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pbj_store import pbj_pkg::*; #(
    parameter int DEPTH = PBJ_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  wire logic [SAMPLE_W-1:0]         wr_data,
    input  wire logic                        rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]    rd_addr,
    output logic      [SAMPLE_W-1:0]         rd_data
);

    logic [SAMPLE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/pbj_scale.sv
// ----------------------------------------------------------------------------
// pbj_scale
// Shared gain unit: multiply, then truncate toward zero and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module pbj_scale import pbj_pkg::*; (
    input  wire logic                        clk,
    input  wire pbj_scl_ctrl_t               ctrl,
    input  wire logic        [SAMPLE_W-1:0]  sample,
    input  wire logic        [GAIN_W-1:0]    gain,
    output logic signed      [SAMPLE_W-1:0]  scaled
);

    localparam logic signed [PROD_W-1:0] MAX_P = PROD_W'(PBJ_SMP_MAX);
    localparam logic signed [PROD_W-1:0] MIN_P = PROD_W'(PBJ_SMP_MIN);
    localparam logic signed [PROD_W-1:0] RND_P = PROD_W'(255);

    logic signed [PROD_W-1:0] smp_ext;
    logic signed [PROD_W-1:0] gain_ext;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] adj;
    logic signed [PROD_W-1:0] quo;

    // Widen both operands to the product width before the multiply.
    assign smp_ext  = PROD_W'($signed(sample));
    assign gain_ext = PROD_W'({1'b0, gain});

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= smp_ext * gain_ext;
        end
    end

    // Bias negatives so the arithmetic shift rounds toward zero.
    always_comb
    begin
        adj = prod_reg + (prod_reg[PROD_W-1] ? RND_P : '0);
        quo = adj >>> 8;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sat_en)
        begin
            if (quo > MAX_P)
            begin
                scaled <= MAX_P[SAMPLE_W-1:0];
            end
            else if (quo < MIN_P)
            begin
                scaled <= MIN_P[SAMPLE_W-1:0];
            end
            else
            begin
                scaled <= quo[SAMPLE_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire
